// File: rtl/prd_pkg.sv
// prd_pkg: shared types and constants of the pulse rate detector
// no dependencies; used by the interfaces, the divider, the detector and the checker
`timescale 1ns / 1ps

package prd_pkg;

	// payload field widths
	localparam int SAMPLE_W = 10;
	localparam int TIME_W   = 32;
	localparam int RATE_W   = 16;
	localparam int MEAN_W   = 10;
	localparam int PREV_W   = 17;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 8'd1;

	// reset values and fixed numbers
	localparam logic [CFG_DATA_W-1:0] PRESENCE_RST = 10'd150;
	localparam logic [CFG_DATA_W-1:0] LIMIT_RST    = 10'd300;
	localparam logic [RATE_W-1:0]     RATE_NUM     = 16'd60000;
	localparam logic [PREV_W-1:0]     PREV_NONE    = 17'h1FFFF;
	localparam int                    DVS_W        = 32;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRD,
		ST_WUPD,
		ST_DBASE,
		ST_CMP,
		ST_IVL,
		ST_DRATE,
		ST_HRD,
		ST_HUPD,
		ST_HMEAN,
		ST_DMEAN,
		ST_FIN
	} st_t;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/prd_if.sv
// prd_if: valid/ready channel interfaces for samples, results and configuration
// depends on prd_pkg for field widths
`timescale 1ns / 1ps

interface prd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [prd_pkg::SAMPLE_W-1:0]  sample;
	logic [prd_pkg::TIME_W-1:0]    time_ms;

	modport source (output valid, output sample, output time_ms, input ready);
	modport sink (input valid, input sample, input time_ms, output ready);
endinterface

interface prd_result_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic [prd_pkg::RATE_W-1:0]  beat_rate;
	logic                        rate_valid;
	logic [prd_pkg::MEAN_W-1:0]  mean_rate;
	logic                        zero_interval;

	modport source (output valid, output accepted, output beat_rate, output rate_valid,
		output mean_rate, output zero_interval, input ready);
	modport sink (input valid, input accepted, input beat_rate, input rate_valid,
		input mean_rate, input zero_interval, output ready);
endinterface

interface prd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [prd_pkg::CFG_IDX_W-1:0]   index;
	logic [prd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/prd_ram.sv
// prd_ram: single-port store with registered read and per-entry valid bits
// depends on nothing; an entry never written reads as zero
`timescale 1ns / 1ps

module prd_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 10,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [AW-1:0]    addr,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rvld_q;

	// storage array, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
	end

	// valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[addr];
			if (wr_en) begin
				vld_q[addr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rd_q : '0;

endmodule

// File: rtl/prd_div.sv
// prd_div: restoring serial divider, one quotient bit per cycle
// depends on prd_pkg for the status struct and divisor width
`timescale 1ns / 1ps

module prd_div #(
	parameter int DVD_W = 16,
	localparam int CW = $clog2(DVD_W + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DVD_W-1:0]          dividend,
	input  logic [prd_pkg::DVS_W-1:0] divisor,
	output prd_pkg::div_stat_t        stat,
	output logic [DVD_W-1:0]          quotient
);

	logic [prd_pkg::DVS_W-1:0] rem_q;
	logic [prd_pkg::DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0]          quo_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [prd_pkg::DVS_W:0]   trial;
	logic [prd_pkg::DVS_W:0]   diff;
	logic                      qbit;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[prd_pkg::DVS_W-1:0] : trial[prd_pkg::DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], qbit};
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// File: rtl/pulse_rate_detector.sv
// pulse_rate_detector: heart rate from pulse-sensor samples, one shared serial divider
// depends on prd_pkg, prd_if, prd_ram and prd_div
// a rejected sample goes straight to the finish state; an accepted sample may have its
// beat rate and then its history mean divided by the shared divider
// throughput: one item at a time, next item taken the cycle after the result loads; a full
// output register stalls. reset clears all but the captured sample and output payload
`timescale 1ns / 1ps

module pulse_rate_detector #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	prd_sample_if.sink         sample_ch,
	prd_result_if.source       result_ch,
	prd_cfg_if.sink            cfg_ch
);

	localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W = prd_pkg::SAMPLE_W + PTR_W;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int DIV_W = (SUM_W > prd_pkg::RATE_W) ? SUM_W : prd_pkg::RATE_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
	// window mean by reciprocal multiply, exact for every window sum
	localparam int BASE_SH = SUM_W + PTR_W;
	localparam int RECIP_W = SUM_W + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] BASE_RECIP =
		RECIP_W'(((1 << BASE_SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

	prd_pkg::st_t state_q, state_d;

	// configuration
	logic [prd_pkg::CFG_DATA_W-1:0] thr_q, lim_q;

	// item and block state
	logic [prd_pkg::SAMPLE_W-1:0] smp_q;
	logic [prd_pkg::TIME_W-1:0]   now_q;
	logic [SUM_W-1:0]             win_sum_q;
	logic [PTR_W-1:0]             win_ptr_q;
	logic                         win_full_q;
	logic [prd_pkg::SAMPLE_W-1:0] base_q;
	logic                         above_q;
	logic [prd_pkg::TIME_W-1:0]   last_q, prior_q;
	logic [prd_pkg::RATE_W-1:0]   rate_q;
	logic [prd_pkg::PREV_W-1:0]   prev_q;
	logic [PTR_W-1:0]             hist_ptr_q;
	logic [SUM_W-1:0]             hist_sum_q;
	logic [CNT_W-1:0]             hist_cnt_q;
	logic [prd_pkg::MEAN_W-1:0]   mean_q;
	logic                         acc_q, zero_q;

	// output register
	logic                         o_vld_q, o_acc_q, o_rvld_q, o_zero_q;
	logic [prd_pkg::RATE_W-1:0]   o_rate_q;
	logic [prd_pkg::MEAN_W-1:0]   o_mean_q;

	// combinational controls
	logic                         in_take, out_load;
	logic                         win_we, hist_we;
	logic                         div_start;
	logic [DIV_W-1:0]             div_dvd, div_quo;
	logic [prd_pkg::DVS_W-1:0]    div_dvs;
	prd_pkg::div_stat_t           div_stat;
	logic [prd_pkg::SAMPLE_W-1:0] win_old;
	logic [prd_pkg::MEAN_W-1:0]   hist_old, hist_new;
	logic [SUM_W-1:0]             win_sum_new, hist_sum_new;
	logic [CNT_W-1:0]             hist_cnt_new;
	logic                         win_full_new;
	logic [prd_pkg::TIME_W-1:0]   ivl;
	logic [prd_pkg::RATE_W-1:0]   quo_rate;
	logic                         rate_store;
	logic [PROD_W-1:0]            base_prod;

	// sample window and rate history stores
	prd_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(prd_pkg::SAMPLE_W)) u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (win_ptr_q),
		.wr_en  (win_we),
		.wdata  (smp_q),
		.rdata  (win_old)
	);

	prd_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(prd_pkg::MEAN_W)) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (hist_ptr_q),
		.wr_en  (hist_we),
		.wdata  (hist_new),
		.rdata  (hist_old)
	);

	// shared divider: beat rate and history mean
	prd_div #(.DVD_W(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// arithmetic around the stores
	always_comb begin
		win_sum_new  = win_sum_q - SUM_W'(win_old) + SUM_W'(smp_q);
		win_full_new = win_full_q | (win_ptr_q == PTR_LAST);
		hist_new     = rate_q[prd_pkg::MEAN_W-1:0];
		hist_sum_new = hist_sum_q - SUM_W'(hist_old) + SUM_W'(hist_new);
		hist_cnt_new = hist_cnt_q - CNT_W'(hist_old != '0) + CNT_W'(hist_new != '0);
		ivl          = last_q - prior_q;
		quo_rate     = div_quo[prd_pkg::RATE_W-1:0];
		rate_store   = (quo_rate < prd_pkg::RATE_W'(lim_q))
			&& ({1'b0, quo_rate} != prev_q);
		base_prod    = PROD_W'(win_sum_q) * PROD_W'(BASE_RECIP);
	end

	// sequencer: next state and controls
	always_comb begin
		state_d   = state_q;
		in_take   = 1'b0;
		out_load  = 1'b0;
		win_we    = 1'b0;
		hist_we   = 1'b0;
		div_start = 1'b0;
		div_dvd   = DIV_W'(win_sum_new);
		div_dvs   = prd_pkg::DVS_W'(WINDOW_DEPTH);
		case (state_q)
			prd_pkg::ST_IDLE: begin
				in_take = sample_ch.valid;
				if (sample_ch.valid) begin
					state_d = (sample_ch.sample > thr_q) ? prd_pkg::ST_WRD : prd_pkg::ST_FIN;
				end
			end
			prd_pkg::ST_WRD: begin
				state_d = prd_pkg::ST_WUPD;
			end
			prd_pkg::ST_WUPD: begin
				win_we = 1'b1;
				if (win_full_new) begin
					state_d = prd_pkg::ST_DBASE;
				end else begin
					state_d = prd_pkg::ST_CMP;
				end
			end
			prd_pkg::ST_DBASE: begin
				state_d = prd_pkg::ST_CMP;
			end
			prd_pkg::ST_CMP: begin
				state_d = (smp_q > base_q) ? prd_pkg::ST_IVL : prd_pkg::ST_FIN;
			end
			prd_pkg::ST_IVL: begin
				div_dvd = DIV_W'(prd_pkg::RATE_NUM);
				div_dvs = ivl;
				if (ivl == '0) begin
					state_d = prd_pkg::ST_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = prd_pkg::ST_DRATE;
				end
			end
			prd_pkg::ST_DRATE: begin
				if (div_stat.done) begin
					state_d = rate_store ? prd_pkg::ST_HRD : prd_pkg::ST_FIN;
				end
			end
			prd_pkg::ST_HRD: begin
				state_d = prd_pkg::ST_HUPD;
			end
			prd_pkg::ST_HUPD: begin
				hist_we = 1'b1;
				state_d = prd_pkg::ST_HMEAN;
			end
			prd_pkg::ST_HMEAN: begin
				div_dvd = DIV_W'(hist_sum_q);
				div_dvs = prd_pkg::DVS_W'(hist_cnt_q);
				if (hist_cnt_q == '0) begin
					state_d = prd_pkg::ST_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = prd_pkg::ST_DMEAN;
				end
			end
			prd_pkg::ST_DMEAN: begin
				if (div_stat.done) begin
					state_d = prd_pkg::ST_FIN;
				end
			end
			prd_pkg::ST_FIN: begin
				if (!o_vld_q || result_ch.ready) begin
					out_load = 1'b1;
					state_d  = prd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prd_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= prd_pkg::PRESENCE_RST;
			lim_q <= prd_pkg::LIMIT_RST;
		end else if (cfg_ch.valid) begin
			if (cfg_ch.index == prd_pkg::REG_PRESENCE) begin
				thr_q <= cfg_ch.data;
			end else if (cfg_ch.index == prd_pkg::REG_LIMIT) begin
				lim_q <= cfg_ch.data;
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			smp_q <= sample_ch.sample;
			now_q <= sample_ch.time_ms;
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_sum_q  <= '0;
			win_ptr_q  <= '0;
			win_full_q <= 1'b0;
			base_q     <= '0;
			above_q    <= 1'b0;
			last_q     <= '0;
			prior_q    <= '0;
			rate_q     <= '0;
			prev_q     <= prd_pkg::PREV_NONE;
			hist_ptr_q <= '0;
			hist_sum_q <= '0;
			hist_cnt_q <= '0;
			mean_q     <= '0;
			acc_q      <= 1'b0;
			zero_q     <= 1'b0;
		end else begin
			case (state_q)
				prd_pkg::ST_IDLE: begin
					if (in_take) begin
						acc_q  <= sample_ch.sample > thr_q;
						zero_q <= 1'b0;
					end
				end
				prd_pkg::ST_WUPD: begin
					win_sum_q  <= win_sum_new;
					win_full_q <= win_full_new;
					win_ptr_q  <= (win_ptr_q == PTR_LAST) ? '0 : win_ptr_q + PTR_W'(1);
				end
				prd_pkg::ST_DBASE: begin
					base_q <= base_prod[BASE_SH +: prd_pkg::SAMPLE_W];
				end
				prd_pkg::ST_CMP: begin
					if (smp_q > base_q) begin
						if (!above_q) begin
							prior_q <= last_q;
							last_q  <= now_q;
						end
						above_q <= 1'b1;
					end else begin
						above_q <= 1'b0;
					end
				end
				prd_pkg::ST_IVL: begin
					if (ivl == '0) begin
						zero_q <= 1'b1;
					end
				end
				prd_pkg::ST_DRATE: begin
					if (div_stat.done) begin
						rate_q <= quo_rate;
					end
				end
				prd_pkg::ST_HUPD: begin
					hist_sum_q <= hist_sum_new;
					hist_cnt_q <= hist_cnt_new;
					hist_ptr_q <= (hist_ptr_q == PTR_LAST) ? '0 : hist_ptr_q + PTR_W'(1);
					prev_q     <= {1'b0, rate_q};
				end
				prd_pkg::ST_HMEAN: begin
					if (hist_cnt_q == '0) begin
						mean_q <= '0;
					end
				end
				prd_pkg::ST_DMEAN: begin
					if (div_stat.done) begin
						mean_q <= div_quo[prd_pkg::MEAN_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
		end else if (out_load) begin
			o_vld_q <= 1'b1;
		end else if (result_ch.ready) begin
			o_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_acc_q  <= acc_q;
			o_rate_q <= rate_q;
			o_rvld_q <= rate_q < prd_pkg::RATE_W'(lim_q);
			o_mean_q <= mean_q;
			o_zero_q <= zero_q;
		end
	end

	// ports
	assign sample_ch.ready         = (state_q == prd_pkg::ST_IDLE);
	assign cfg_ch.ready            = 1'b1;
	assign result_ch.valid         = o_vld_q;
	assign result_ch.accepted      = o_acc_q;
	assign result_ch.beat_rate     = o_rate_q;
	assign result_ch.rate_valid    = o_rvld_q;
	assign result_ch.mean_rate     = o_mean_q;
	assign result_ch.zero_interval = o_zero_q;

	// divider is never restarted while it iterates
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// a new result is only loaded from the finish state
	a_load_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == prd_pkg::ST_FIN))
		else $error("result loaded outside finish state");

	// once filled, the window stays full
	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		win_full_q |=> win_full_q)
		else $error("window full flag dropped");

	// nonzero history count never exceeds the history depth
	a_hist_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		hist_cnt_q <= CNT_W'(WINDOW_DEPTH))
		else $error("history count out of range");

endmodule

// File: verif/prd_beat_checker.sv
// prd_beat_checker: watches the sample, result and configuration channels of the
// pulse rate detector, predicts every result and compares it field by field
// depends on prd_pkg
`timescale 1ns / 1ps

module prd_beat_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	input  logic                           sample_ready,
	input  logic [prd_pkg::SAMPLE_W-1:0]   sample,
	input  logic [prd_pkg::TIME_W-1:0]     time_ms,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  logic                           accepted,
	input  logic [prd_pkg::RATE_W-1:0]     beat_rate,
	input  logic                           rate_valid,
	input  logic [prd_pkg::MEAN_W-1:0]     mean_rate,
	input  logic                           zero_interval,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             outstanding
);

	localparam int WIN = 16;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic                       accepted;
		logic [prd_pkg::RATE_W-1:0] beat_rate;
		logic                       rate_valid;
		logic [prd_pkg::MEAN_W-1:0] mean_rate;
		logic                       zero_interval;
	} beat_result_t;

	beat_result_t expected_beats[$];

	// predicted block state
	logic [prd_pkg::CFG_DATA_W-1:0] thr_reg;
	logic [prd_pkg::CFG_DATA_W-1:0] limit_reg;
	logic [prd_pkg::SAMPLE_W-1:0]   win[WIN];
	logic [13:0]                    win_sum;
	logic [3:0]                     win_ptr;
	logic                           win_full;
	logic [prd_pkg::SAMPLE_W-1:0]   base;
	logic                           above;
	logic [prd_pkg::TIME_W-1:0]     last_rise;
	logic [prd_pkg::TIME_W-1:0]     prior_rise;
	logic [prd_pkg::RATE_W-1:0]     cur_rate;
	logic [prd_pkg::PREV_W-1:0]     prev_rate;
	logic [prd_pkg::MEAN_W-1:0]     hist[WIN];
	logic [3:0]                     hist_ptr;
	logic [prd_pkg::MEAN_W-1:0]     mean_reg;

	// advance the predicted state by one sample and queue the result it causes
	task automatic predict_beat(input logic [prd_pkg::SAMPLE_W-1:0] s,
		input logic [prd_pkg::TIME_W-1:0] now);
		beat_result_t r;
		logic [prd_pkg::TIME_W-1:0] interval;
		logic zero_iv;
		int unsigned total;
		int unsigned cnt;
		zero_iv = 1'b0;
		if (s > thr_reg) begin
			win_sum = win_sum - 14'(win[win_ptr]) + 14'(s);
			win[win_ptr] = s;
			if (win_ptr == 4'(WIN - 1))
				win_full = 1'b1;
			win_ptr = win_ptr + 4'd1;
			if (win_full)
				base = prd_pkg::SAMPLE_W'(win_sum / WIN);
			if (s > base) begin
				// a new rise moves the rise times along
				if (!above) begin
					prior_rise = last_rise;
					last_rise = now;
				end
				above = 1'b1;
				interval = last_rise - prior_rise;
				if (interval == '0) begin
					zero_iv = 1'b1;
				end else begin
					cur_rate = prd_pkg::RATE_W'(32'(prd_pkg::RATE_NUM) / interval);
					if (cur_rate < limit_reg && {1'b0, cur_rate} != prev_rate) begin
						hist[hist_ptr] = cur_rate[prd_pkg::MEAN_W-1:0];
						hist_ptr = hist_ptr + 4'd1;
						prev_rate = {1'b0, cur_rate};
						// mean over the nonzero history entries
						total = 0;
						cnt = 0;
						foreach (hist[k]) begin
							if (hist[k] != '0) begin
								total += hist[k];
								cnt++;
							end
						end
						mean_reg = (cnt == 0) ? '0 : prd_pkg::MEAN_W'(total / cnt);
					end
				end
			end else begin
				above = 1'b0;
			end
		end
		r.accepted = s > thr_reg;
		r.beat_rate = cur_rate;
		r.rate_valid = cur_rate < limit_reg;
		r.mean_rate = mean_reg;
		r.zero_interval = zero_iv;
		expected_beats.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		beat_result_t want;
		beat_result_t got;
		if (!arst_n) begin
			thr_reg = prd_pkg::PRESENCE_RST;
			limit_reg = prd_pkg::LIMIT_RST;
			foreach (win[k]) begin
				win[k] = '0;
				hist[k] = '0;
			end
			win_sum = '0;
			win_ptr = '0;
			win_full = 1'b0;
			base = '0;
			above = 1'b0;
			last_rise = '0;
			prior_rise = '0;
			cur_rate = '0;
			prev_rate = prd_pkg::PREV_NONE;
			hist_ptr = '0;
			mean_reg = '0;
			expected_beats.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			// register writes; unknown indexes change nothing
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == prd_pkg::REG_PRESENCE)
					thr_reg = cfg_data;
				else if (cfg_index == prd_pkg::REG_LIMIT)
					limit_reg = cfg_data;
			end
			if (sample_valid && sample_ready)
				predict_beat(sample, time_ms);
			// compare each result with the oldest prediction
			if (result_valid && result_ready) begin
				got.accepted = accepted;
				got.beat_rate = beat_rate;
				got.rate_valid = rate_valid;
				got.mean_rate = mean_rate;
				got.zero_interval = zero_interval;
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("[%0t] result with nothing predicted: %s%0d %0d %0d %0d %0d",
							$time, "acc/rate/valid/mean/zero=", got.accepted,
							got.beat_rate, got.rate_valid, got.mean_rate,
							got.zero_interval);
				end else begin
					want = expected_beats.pop_front();
					if (want.accepted !== got.accepted || want.beat_rate !== got.beat_rate ||
						want.rate_valid !== got.rate_valid || want.mean_rate !== got.mean_rate ||
						want.zero_interval !== got.zero_interval) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("[%0t] result mismatch: expected acc=%0d rate=%0d %s%0d %s%0d %s%0d",
								$time, want.accepted, want.beat_rate,
								"valid=", want.rate_valid, "mean=", want.mean_rate,
								"zero=", want.zero_interval);
							$display("[%0t]                  got      acc=%0d rate=%0d %s%0d %s%0d %s%0d",
								$time, got.accepted, got.beat_rate,
								"valid=", got.rate_valid, "mean=", got.mean_rate,
								"zero=", got.zero_interval);
						end
					end
				end
			end
			outstanding <= expected_beats.size();
		end
	end

endmodule

// File: verif/pulse_rate_detector_tb.sv
// pulse_rate_detector_tb: drives samples and register writes into the pulse rate
// detector with random idling on both channels and gives the verdict
// depends on prd_pkg, prd_if, pulse_rate_detector and prd_beat_checker
`timescale 1ns / 1ps

module pulse_rate_detector_tb;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 6;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 70;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [prd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

	logic clk;
	logic arst_n = 1'b0;

	prd_sample_if sample_ch();
	prd_result_if result_ch();
	prd_cfg_if    cfg_ch();

	int fail_count;
	int pending;

	// stimulus state
	int unsigned items_sent = 0;
	int unsigned last_period = 800;
	int unsigned gap_pct = 0;
	int unsigned hold_requests = 0;
	logic [prd_pkg::TIME_W-1:0]     clock_ms = '0;
	logic [prd_pkg::CFG_DATA_W-1:0] cur_thr = prd_pkg::PRESENCE_RST;
	logic                           calm = 1'b0;

	pulse_rate_detector #(
		.WINDOW_DEPTH(16)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	prd_beat_checker beat_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_ch.valid),
		.sample_ready  (sample_ch.ready),
		.sample        (sample_ch.sample),
		.time_ms       (sample_ch.time_ms),
		.result_valid  (result_ch.valid),
		.result_ready  (result_ch.ready),
		.accepted      (result_ch.accepted),
		.beat_rate     (result_ch.beat_rate),
		.rate_valid    (result_ch.rate_valid),
		.mean_rate     (result_ch.mean_rate),
		.zero_interval (result_ch.zero_interval),
		.cfg_valid     (cfg_ch.valid),
		.cfg_ready     (cfg_ch.ready),
		.cfg_index     (cfg_ch.index),
		.cfg_data      (cfg_ch.data),
		.fail_count    (fail_count),
		.outstanding   (pending)
	);

	// clock
	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// offer one sample item, with a random gap in front of it
	task automatic send_item(input logic [prd_pkg::SAMPLE_W-1:0] s,
		input logic [prd_pkg::TIME_W-1:0] t);
		if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		sample_ch.time_ms <= t;
		do @(posedge clk); while (!sample_ch.ready);
		items_sent++;
	endtask

	// one register write item; the caller lowers valid after the last one
	task automatic write_reg(input logic [prd_pkg::CFG_IDX_W-1:0] idx,
		input logic [prd_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic configure(input logic [prd_pkg::CFG_DATA_W-1:0] thr,
		input logic [prd_pkg::CFG_DATA_W-1:0] lim, input bit poke_unused);
		write_reg(prd_pkg::REG_PRESENCE, thr);
		write_reg(prd_pkg::REG_LIMIT, lim);
		if (poke_unused)
			write_reg(REG_UNUSED, prd_pkg::CFG_DATA_W'($urandom_range(0, 1023)));
		cfg_ch.valid <= 1'b0;
		cur_thr = thr;
	endtask

	// stop offering, wait for every predicted result, then let the block go quiet
	task automatic settle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// low sample just before a rise, then a high sample at the rise time
	task automatic directed_beat(input logic [prd_pkg::TIME_W-1:0] rise);
		send_item(10'd200, rise - 32'd1);
		send_item(10'd1023, rise);
	endtask

	// one heartbeat: a trough, a peak after a random period, sometimes a dropout
	task automatic pulse_beat();
		int unsigned n_low;
		int unsigned n_high;
		int unsigned period;
		int unsigned k;
		n_low = $urandom_range(1, 3);
		n_high = $urandom_range(1, 3);
		case ($urandom_range(0, 19))
			0: period = 0;
			1: period = $urandom_range(60001, 200000);
			2: period = $urandom_range(1, 150);
			3, 4, 5, 6, 7: period = last_period;
			default: period = $urandom_range(150, 2500);
		endcase
		last_period = period;
		for (k = 0; k < n_low; k++)
			send_item(prd_pkg::SAMPLE_W'($urandom_range(160, 420)), clock_ms + 32'(k * 7 + 3));
		clock_ms = clock_ms + period;
		for (k = 0; k < n_high; k++)
			send_item(prd_pkg::SAMPLE_W'($urandom_range(700, 1023)), clock_ms + 32'(k * 9));
		if ($urandom_range(0, 9) == 0)
			send_item(prd_pkg::SAMPLE_W'($urandom_range(cur_thr, 0)), $urandom());
	endtask

	// mostly heartbeats, some random noise samples
	task automatic run_pulses(input int unsigned n);
		int unsigned stop;
		stop = items_sent + n;
		while (items_sent < stop) begin
			if ($urandom_range(0, 6) == 0)
				send_item(prd_pkg::SAMPLE_W'($urandom_range(0, 1023)), $urandom());
			else
				pulse_beat();
		end
	endtask

	// result side: random stalls, plus a long hold on request
	initial begin : result_sink
		int unsigned holds_served;
		holds_served = 0;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ends the run when no channel moves an item for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("pulse_rate_detector_tb: FAIL");
		$finish;
	end

	// stimulus and verdict
	initial begin : stimulus
		int unsigned k;
		sample_ch.valid <= 1'b0;
		sample_ch.sample <= '0;
		sample_ch.time_ms <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: threshold edge, window fill, special intervals, wrap
		gap_pct = 20;
		send_item(10'd0, 32'd0);
		send_item(10'd150, 32'hFFFF_FFFF);
		send_item(10'd151, 32'd0);
		for (k = 0; k < 15; k++)
			send_item(k[0] ? 10'd200 : 10'd1023, 32'(k * 10 + 10));
		directed_beat(32'hFFFF_FF00);
		directed_beat(32'h0000_0100);
		directed_beat(32'h0000_0100);
		directed_beat(32'h0000_0164);
		directed_beat(32'h0000_0364);
		settle();

		// widest acceptance and rate range
		configure(10'd0, 10'd1023, 1'b0);
		clock_ms = $urandom();
		run_pulses(60);
		settle();

		// everything rejected, rate limit of one
		gap_pct = 30;
		configure(10'd1023, 10'd1, 1'b1);
		run_pulses(15);
		settle();

		// defaults with a long result hold so the block backs up
		gap_pct = 10;
		configure(prd_pkg::PRESENCE_RST, prd_pkg::LIMIT_RST, 1'b0);
		hold_requests <= hold_requests + 1;
		run_pulses(70);
		settle();

		// no rate ever stored
		gap_pct = 25;
		configure(prd_pkg::CFG_DATA_W'($urandom_range(0, 200)), 10'd0, 1'b0);
		run_pulses(60);
		settle();

		// back-to-back samples, random settings
		gap_pct = 0;
		configure(prd_pkg::CFG_DATA_W'($urandom_range(0, 300)),
			prd_pkg::CFG_DATA_W'($urandom_range(1, 1023)), 1'b1);
		run_pulses(60);
		settle();

		// timestamps running through the wrap
		gap_pct = 40;
		configure(10'd100, 10'd250, 1'b0);
		clock_ms = 32'hFFFF_F000;
		run_pulses(60);
		settle();

		gap_pct = 15;
		configure(prd_pkg::CFG_DATA_W'($urandom_range(0, 400)),
			prd_pkg::CFG_DATA_W'($urandom_range(1, 1023)), 1'b0);
		run_pulses(70);
		settle();

		// closing stretch with no idling on either side
		calm <= 1'b1;
		configure(prd_pkg::PRESENCE_RST, 10'd1023, 1'b0);
		run_pulses(90);
		settle();

		if (fail_count == 0 && pending == 0)
			$display("pulse_rate_detector_tb: PASS");
		else
			$display("pulse_rate_detector_tb: FAIL");
		$finish;
	end

endmodule
